>>> design/mqttrx_pkg.sv
// mqttrx_pkg: shared types, constants and the start-byte decode for the mqtt receive parser
// no dependencies; used by every module in design/
`default_nettype none

package mqttrx_pkg;

    localparam logic [7:0] START_CONNACK = 8'h20;
    localparam logic [7:0] START_SUBACK  = 8'h90;
    localparam logic [7:0] START_PUBLISH = 8'h30;
    localparam logic [7:0] CONNACK_LEN   = 8'h02;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;
    localparam logic [7:0] LEN_LIMIT     = 8'd127;
    localparam logic [7:0] PKT_ID_RESET  = 8'd1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int LEN_W       = 7;

    typedef enum logic [2:0] {
        KIND_TOPIC   = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_CONNACK = 3'd2,
        KIND_SUBACK  = 3'd3,
        KIND_REJECT  = 3'd4,
        KIND_EMPTY   = 3'd5
    } kind_t;

    typedef enum logic [11:0] {
        PH_HUNT      = 12'b0000_0000_0001,
        PH_CA_LEN    = 12'b0000_0000_0010,
        PH_CA_FLAGS  = 12'b0000_0000_0100,
        PH_CA_CODE   = 12'b0000_0000_1000,
        PH_SA_ANY    = 12'b0000_0001_0000,
        PH_SA_HIGH   = 12'b0000_0010_0000,
        PH_SA_ID     = 12'b0000_0100_0000,
        PH_PUB_LEN   = 12'b0000_1000_0000,
        PH_PUB_TOPH  = 12'b0001_0000_0000,
        PH_PUB_TOPL  = 12'b0010_0000_0000,
        PH_PUB_TOPIC = 12'b0100_0000_0000,
        PH_PUB_PAY   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       frame_end;
    } result_t;

    // next phase when a byte is looked at as a possible start byte
    function automatic phase_t hunt_phase(input logic [7:0] b);
        phase_t ph;
        if (b == START_CONNACK) begin
            ph = PH_CA_LEN;
        end else if (b == START_SUBACK) begin
            ph = PH_SA_ANY;
        end else if (b == START_PUBLISH) begin
            ph = PH_PUB_LEN;
        end else begin
            ph = PH_HUNT;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

>>> design/mqttrx_in_stage.sv
// mqttrx_in_stage: input register for received bytes
// depends on mqttrx_pkg
`default_nettype none

module mqttrx_in_stage (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [mqttrx_pkg::IN_TDATA_W-1:0] s_data,
    input  wire logic                             take,
    output logic                                  byte_valid,
    output logic [mqttrx_pkg::IN_TDATA_W-1:0]     rx_byte
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [mqttrx_pkg::IN_TDATA_W-1:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

`default_nettype wire

>>> design/mqttrx_parser.sv
// mqttrx_parser: packet phase tracking, publish length bookkeeping and result decode
// depends on mqttrx_pkg
`default_nettype none

module mqttrx_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    input  wire logic                 step,
    input  wire logic [7:0]           rx_byte,
    output logic                      res_emit,
    output mqttrx_pkg::result_t       res
);

    localparam int LW = mqttrx_pkg::LEN_W;

    mqttrx_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0]      frame_len_reg, frame_len_next;
    logic [LW-1:0]      topic_left_reg, topic_left_next;
    logic [LW-1:0]      payload_left_reg, payload_left_next;
    logic [7:0]         pkt_id_reg;
    logic [LW-1:0]      topic_dec;
    logic [LW-1:0]      payload_dec;
    logic [LW-1:0]      payload_len;
    logic               topic_too_long;

    assign topic_dec      = topic_left_reg - LW'(1);
    assign payload_dec    = payload_left_reg - LW'(1);
    assign payload_len    = frame_len_reg - LW'(2) - rx_byte[LW-1:0];
    assign topic_too_long = rx_byte[7] ||
                            ({1'b0, rx_byte} + 9'd2 > {2'b00, frame_len_reg});

    always_comb begin
        phase_next        = phase_reg;
        frame_len_next    = frame_len_reg;
        topic_left_next   = topic_left_reg;
        payload_left_next = payload_left_reg;
        res_emit          = 1'b0;
        res.kind          = mqttrx_pkg::KIND_TOPIC;
        res.data_byte     = mqttrx_pkg::ZERO_BYTE;
        res.frame_end     = 1'b1;
        case (phase_reg)
            mqttrx_pkg::PH_CA_LEN: begin
                phase_next = (rx_byte == mqttrx_pkg::CONNACK_LEN) ? mqttrx_pkg::PH_CA_FLAGS
                                                                  : mqttrx_pkg::hunt_phase(rx_byte);
            end
            mqttrx_pkg::PH_CA_FLAGS: begin
                phase_next = (rx_byte == mqttrx_pkg::ZERO_BYTE) ? mqttrx_pkg::PH_CA_CODE
                                                                : mqttrx_pkg::hunt_phase(rx_byte);
            end
            mqttrx_pkg::PH_CA_CODE: begin
                if (rx_byte == mqttrx_pkg::ZERO_BYTE) begin
                    phase_next = mqttrx_pkg::PH_HUNT;
                    res_emit   = 1'b1;
                    res.kind   = mqttrx_pkg::KIND_CONNACK;
                end else begin
                    phase_next = mqttrx_pkg::hunt_phase(rx_byte);
                end
            end
            mqttrx_pkg::PH_SA_ANY: begin
                phase_next = mqttrx_pkg::PH_SA_HIGH;
            end
            mqttrx_pkg::PH_SA_HIGH: begin
                phase_next = (rx_byte == mqttrx_pkg::ZERO_BYTE) ? mqttrx_pkg::PH_SA_ID
                                                                : mqttrx_pkg::hunt_phase(rx_byte);
            end
            mqttrx_pkg::PH_SA_ID: begin
                if (rx_byte == pkt_id_reg) begin
                    phase_next = mqttrx_pkg::PH_HUNT;
                    res_emit   = 1'b1;
                    res.kind   = mqttrx_pkg::KIND_SUBACK;
                end else begin
                    phase_next = mqttrx_pkg::hunt_phase(rx_byte);
                end
            end
            mqttrx_pkg::PH_PUB_LEN: begin
                if (rx_byte >= mqttrx_pkg::LEN_LIMIT) begin
                    phase_next = mqttrx_pkg::PH_HUNT;
                    res_emit   = 1'b1;
                    res.kind   = mqttrx_pkg::KIND_REJECT;
                end else begin
                    frame_len_next = rx_byte[LW-1:0];
                    phase_next     = mqttrx_pkg::PH_PUB_TOPH;
                end
            end
            mqttrx_pkg::PH_PUB_TOPH: begin
                // topic length high byte is ignored
                phase_next = mqttrx_pkg::PH_PUB_TOPL;
            end
            mqttrx_pkg::PH_PUB_TOPL: begin
                if (topic_too_long) begin
                    phase_next = mqttrx_pkg::PH_HUNT;
                    res_emit   = 1'b1;
                    res.kind   = mqttrx_pkg::KIND_REJECT;
                end else begin
                    topic_left_next   = rx_byte[LW-1:0];
                    payload_left_next = payload_len;
                    if (rx_byte != mqttrx_pkg::ZERO_BYTE) begin
                        phase_next = mqttrx_pkg::PH_PUB_TOPIC;
                    end else if (payload_len != '0) begin
                        phase_next = mqttrx_pkg::PH_PUB_PAY;
                    end else begin
                        phase_next = mqttrx_pkg::PH_HUNT;
                        res_emit   = 1'b1;
                        res.kind   = mqttrx_pkg::KIND_EMPTY;
                    end
                end
            end
            mqttrx_pkg::PH_PUB_TOPIC: begin
                topic_left_next = topic_dec;
                res_emit        = 1'b1;
                res.kind        = mqttrx_pkg::KIND_TOPIC;
                res.data_byte   = rx_byte;
                res.frame_end   = (topic_dec == '0) && (payload_left_reg == '0);
                if (topic_dec == '0) begin
                    phase_next = (payload_left_reg != '0) ? mqttrx_pkg::PH_PUB_PAY
                                                          : mqttrx_pkg::PH_HUNT;
                end
            end
            mqttrx_pkg::PH_PUB_PAY: begin
                payload_left_next = payload_dec;
                res_emit          = 1'b1;
                res.kind          = mqttrx_pkg::KIND_PAYLOAD;
                res.data_byte     = rx_byte;
                res.frame_end     = (payload_dec == '0);
                if (payload_dec == '0) begin
                    phase_next = mqttrx_pkg::PH_HUNT;
                end
            end
            default: begin
                phase_next = mqttrx_pkg::hunt_phase(rx_byte);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= mqttrx_pkg::PH_HUNT;
            frame_len_reg    <= '0;
            topic_left_reg   <= '0;
            payload_left_reg <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            frame_len_reg    <= frame_len_next;
            topic_left_reg   <= topic_left_next;
            payload_left_reg <= payload_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_id_reg <= mqttrx_pkg::PKT_ID_RESET;
        end else if (cfg_wr_en) begin
            pkt_id_reg <= cfg_wr_data;
        end
    end

    // acknowledge, reject and empty results always close their frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_emit && res.kind != mqttrx_pkg::KIND_TOPIC
                  && res.kind != mqttrx_pkg::KIND_PAYLOAD) |-> res.frame_end)
        else $error("non-data result without frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_emit && res.kind != mqttrx_pkg::KIND_TOPIC
                  && res.kind != mqttrx_pkg::KIND_PAYLOAD) |-> (res.data_byte == '0))
        else $error("non-data result carries a data byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_emit && res.frame_end) |=> (phase_reg == mqttrx_pkg::PH_HUNT))
        else $error("parser not hunting after frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mqttrx_pkg::PH_PUB_PAY) |-> (payload_left_reg != '0))
        else $error("payload phase with nothing left");

endmodule

`default_nettype wire

>>> design/mqttrx_out_stage.sv
// mqttrx_out_stage: result register on the master stream side
// depends on mqttrx_pkg
`default_nettype none

module mqttrx_out_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire mqttrx_pkg::result_t           res,
    output logic                               can_take,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mqttrx_pkg::OUT_TDATA_W-1:0] m_data,
    output logic                               m_last
);

    logic                valid_reg;
    logic                valid_next;
    mqttrx_pkg::result_t res_reg;

    assign can_take   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {5'b00000, res_reg.data_byte, res_reg.kind};
    assign m_last  = res_reg.frame_end;

endmodule

`default_nettype wire

>>> design/mqtt_receive_packet_parser.sv
// mqtt_receive_packet_parser: top level of the mqtt receive parser
// depends on mqttrx_pkg, mqttrx_in_stage, mqttrx_parser, mqttrx_out_stage
//
//  channel   dir  width            contents
//  s_axis    in   tdata 8          rx_byte
//  m_axis    out  tdata 16, tlast  kind [2:0], data_byte [10:3]; tlast = frame_end
//  cfg_wr    in   8                expected_packet_id
//
// one byte per cycle sustained while m_axis is ready; a byte is held in the input register
// and its result, if any, is loaded into the output register when the parser takes the byte.
// a byte consumes its parser step whenever the output register is free or draining.
// a stall on m_axis holds the result and backs up into s_axis_tready.
// synchronous active-low reset returns the parser to hunting, id to 1.
`default_nettype none

module mqtt_receive_packet_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [2:0] kind, [10:3] data_byte, [15:11] zero
    output logic              m_axis_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data
);

    logic                byte_valid;
    logic [7:0]          rx_byte;
    logic                take;
    logic                out_can_take;
    logic                res_emit;
    mqttrx_pkg::result_t res;

    // the parser advances on a held item when the result register can accept
    assign take = byte_valid && out_can_take;

    mqttrx_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    mqttrx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .rx_byte     (rx_byte),
        .res_emit    (res_emit),
        .res         (res)
    );

    mqttrx_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_emit),
        .res      (res),
        .can_take (out_can_take),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> tb/mqtt_receive_packet_parser_checker.sv
// checker for mqtt_receive_packet_parser: tracks the parser state from accepted bytes,
// predicts every result item and compares it field by field. depends on mqttrx_pkg.
`timescale 1ns / 1ps

module mqtt_receive_packet_parser_checker
    import mqttrx_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tlast,
    input  wire logic                   cfg_wr_en,
    input  wire logic [7:0]             cfg_wr_data,
    output int                          fail_count,
    output int                          reports_pending,
    output int                          reports_checked,
    output int                          frames_checked,
    output int                          rejects_checked
);

    phase_t           phase;
    logic [LEN_W-1:0] frame_len;
    logic [7:0]       topic_left;
    logic [7:0]       payload_left;
    logic [7:0]       pkt_id;

    result_t parser_reports[$];
    int      errors;
    int      n_checked;
    int      n_frames;
    int      n_rejects;

    initial begin
        fail_count      = 0;
        reports_pending = 0;
        reports_checked = 0;
        frames_checked  = 0;
        rejects_checked = 0;
        errors          = 0;
        n_checked       = 0;
        n_frames        = 0;
        n_rejects       = 0;
    end

    function automatic phase_t restart_phase(input logic [7:0] b);
        case (b)
            START_CONNACK: return PH_CA_LEN;
            START_SUBACK:  return PH_SA_ANY;
            START_PUBLISH: return PH_PUB_LEN;
            default:       return PH_HUNT;
        endcase
    endfunction

    task parse_rx_byte(input logic [7:0] b, output bit made, output result_t r);
        int rest;
        made        = 1'b0;
        r           = '0;
        r.frame_end = 1'b1;
        case (phase)
            PH_CA_LEN: begin
                phase = (b == CONNACK_LEN) ? PH_CA_FLAGS : restart_phase(b);
            end
            PH_CA_FLAGS: begin
                phase = (b == ZERO_BYTE) ? PH_CA_CODE : restart_phase(b);
            end
            PH_CA_CODE: begin
                if (b == ZERO_BYTE) begin
                    phase  = PH_HUNT;
                    made   = 1'b1;
                    r.kind = KIND_CONNACK;
                end else begin
                    phase = restart_phase(b);
                end
            end
            PH_SA_ANY: begin
                phase = PH_SA_HIGH;
            end
            PH_SA_HIGH: begin
                phase = (b == ZERO_BYTE) ? PH_SA_ID : restart_phase(b);
            end
            PH_SA_ID: begin
                if (b == pkt_id) begin
                    phase  = PH_HUNT;
                    made   = 1'b1;
                    r.kind = KIND_SUBACK;
                end else begin
                    phase = restart_phase(b);
                end
            end
            PH_PUB_LEN: begin
                if (b >= LEN_LIMIT) begin
                    phase  = PH_HUNT;
                    made   = 1'b1;
                    r.kind = KIND_REJECT;
                end else begin
                    frame_len = b[LEN_W-1:0];
                    phase     = PH_PUB_TOPH;
                end
            end
            PH_PUB_TOPH: begin
                phase = PH_PUB_TOPL;
            end
            PH_PUB_TOPL: begin
                // a topic that does not fit in the frame is rejected, not wrapped
                if (b > LEN_LIMIT || int'(b) + 2 > int'(frame_len)) begin
                    phase  = PH_HUNT;
                    made   = 1'b1;
                    r.kind = KIND_REJECT;
                end else begin
                    rest         = int'(frame_len) - 2 - int'(b);
                    topic_left   = b;
                    payload_left = rest[7:0];
                    if (topic_left != 0) begin
                        phase = PH_PUB_TOPIC;
                    end else if (payload_left != 0) begin
                        phase = PH_PUB_PAY;
                    end else begin
                        phase  = PH_HUNT;
                        made   = 1'b1;
                        r.kind = KIND_EMPTY;
                    end
                end
            end
            PH_PUB_TOPIC: begin
                topic_left  = topic_left - 8'd1;
                made        = 1'b1;
                r.kind      = KIND_TOPIC;
                r.data_byte = b;
                r.frame_end = (topic_left == 0 && payload_left == 0);
                if (topic_left == 0) begin
                    phase = (payload_left != 0) ? PH_PUB_PAY : PH_HUNT;
                end
            end
            PH_PUB_PAY: begin
                payload_left = payload_left - 8'd1;
                made         = 1'b1;
                r.kind       = KIND_PAYLOAD;
                r.data_byte  = b;
                r.frame_end  = (payload_left == 0);
                if (payload_left == 0) begin
                    phase = PH_HUNT;
                end
            end
            default: begin
                phase = restart_phase(b);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        bit      made;
        if (!aresetn) begin
            phase        = PH_HUNT;
            frame_len    = '0;
            topic_left   = '0;
            payload_left = '0;
            pkt_id       = PKT_ID_RESET;
            parser_reports.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (parser_reports.size() == 0) begin
                    $error("result item with none predicted: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = parser_reports.pop_front();
                    n_checked++;
                    if (want.frame_end) n_frames++;
                    if (want.kind == KIND_REJECT) n_rejects++;
                    if (m_axis_tdata[2:0] !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[10:3] !== want.data_byte) begin
                        $error("data_byte: expected %h, got %h",
                               want.data_byte, m_axis_tdata[10:3]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("frame_end: expected %b, got %b", want.frame_end, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:11] !== '0) begin
                        $error("tdata padding: expected 0, got %h",
                               m_axis_tdata[OUT_TDATA_W-1:11]);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                pkt_id = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_rx_byte(s_axis_tdata, made, got);
                if (made) parser_reports.push_back(got);
            end
        end
        fail_count      <= errors;
        reports_pending <= parser_reports.size();
        reports_checked <= n_checked;
        frames_checked  <= n_frames;
        rejects_checked <= n_rejects;
    end

endmodule

>>> tb/mqtt_receive_packet_parser_tb.sv
// top of the mqtt_receive_packet_parser testbench: clock, reset, byte stream and id writes
// depends on mqttrx_pkg, mqtt_receive_packet_parser and mqtt_receive_packet_parser_checker
`timescale 1ns / 1ps

module mqtt_receive_packet_parser_tb;
    import mqttrx_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 3000;
    localparam int PHASE_BYTES  = 365;
    localparam int GAP_PERCENT  = 33;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_wr_en     = 1'b0;
    logic [7:0]             cfg_wr_data   = '0;

    int fail_count;
    int reports_pending;
    int reports_checked;
    int frames_checked;
    int rejects_checked;

    logic [7:0] line_bytes[$];
    int         bytes_queued = 0;
    int         ids_used     = 1;
    logic [7:0] cur_id       = PKT_ID_RESET;
    bit         gaps_on      = 1'b1;
    int         holds_asked  = 0;
    int         holds_served = 0;
    int         stuck_cycles = 0;

    mqtt_receive_packet_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    mqtt_receive_packet_parser_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked),
        .frames_checked  (frames_checked),
        .rejects_checked (rejects_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // byte sender: holds an item until taken, then offers the next or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (line_bytes.size() != 0 && (!gaps_on || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= line_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off whenever one is asked for
    initial begin
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_axis_tready <= 1'b0;
            end else if (holds_asked != holds_served) begin
                holds_served = holds_served + 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= GAP_PERCENT) : 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        line_bytes.push_back(b);
        bytes_queued++;
    endtask

    // four-byte acknowledge; a broken one has one byte after the header replaced
    task automatic add_ack(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3, input bit broken);
        logic [7:0] seq[4];
        seq = '{b0, b1, b2, b3};
        if (broken) seq[$urandom_range(1, 3)] = 8'($urandom_range(0, 255));
        foreach (seq[i]) push_byte(seq[i]);
    endtask

    // publish header, then a body only when the parser will take one
    task automatic add_publish(input int rem_len, input int topic_len);
        push_byte(START_PUBLISH);
        push_byte(rem_len[7:0]);
        if (rem_len >= int'(LEN_LIMIT)) return;
        push_byte(8'($urandom_range(0, 255)));
        push_byte(topic_len[7:0]);
        if (topic_len > int'(LEN_LIMIT) || topic_len + 2 > rem_len) return;
        repeat (rem_len - 2) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int rem;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                add_ack(START_CONNACK, CONNACK_LEN, ZERO_BYTE, ZERO_BYTE, 1'b0);
            end else if (pick < 22) begin
                add_ack(START_CONNACK, CONNACK_LEN, ZERO_BYTE, ZERO_BYTE, 1'b1);
            end else if (pick < 32) begin
                add_ack(START_SUBACK, 8'($urandom_range(0, 255)), ZERO_BYTE, cur_id, 1'b0);
            end else if (pick < 38) begin
                add_ack(START_SUBACK, 8'($urandom_range(0, 255)), ZERO_BYTE,
                        8'($urandom_range(0, 255)), $urandom_range(0, 1));
            end else if (pick < 80) begin
                // mostly short frames, now and then one near the length limit
                rem = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 126)
                                                   : $urandom_range(2, 16);
                add_publish(rem, $urandom_range(0, rem - 2));
            end else if (pick < 90) begin
                case ($urandom_range(0, 2))
                    0: add_publish($urandom_range(127, 255), 0);
                    1: add_publish($urandom_range(0, 126), $urandom_range(128, 255));
                    default: begin
                        rem = $urandom_range(0, 20);
                        add_publish(rem, $urandom_range((rem > 0) ? rem - 1 : 0, 127));
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic write_id(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_id = v;
        ids_used++;
    endtask

    // waits until every queued byte is sent and every predicted result has come out
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (line_bytes.size() != 0 || s_axis_tvalid || reports_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] phase_ids[5];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        add_ack(START_CONNACK, CONNACK_LEN, ZERO_BYTE, ZERO_BYTE, 1'b0);
        add_ack(START_SUBACK, 8'hFF, ZERO_BYTE, PKT_ID_RESET, 1'b0);
        // broken connack header re-read as a publish start, which is empty
        push_byte(START_CONNACK);
        add_publish(2, 0);
        add_publish(int'(LEN_LIMIT), 0);
        add_publish(255, 0);
        add_publish(126, 255);
        add_publish(3, 2);
        add_publish(4, 1);
        add_publish(3, 1);
        wait_drained();

        phase_ids = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h80,
                      8'($urandom_range(0, 255))};
        foreach (phase_ids[p]) begin
            write_id(phase_ids[p]);
            gaps_on = (p != 2);
            if (p == 1) begin
                holds_asked = holds_asked + 1;
                add_publish(126, 5);
            end
            add_random_traffic(PHASE_BYTES);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("sent %0d bytes under %0d packet id settings, gaps on and off",
                 bytes_queued, ids_used);
        $display("checked %0d results in %0d frames, %0d of them rejected publishes",
                 reports_checked, frames_checked, rejects_checked);
        if (fail_count == 0 && reports_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
